/* design/gwd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwd_pkg: shared types and constants for the GPS week to date converter
// Holds widths, epoch constants, the sequencer states and the month table.
// ----------------------------------------------------------------------------
package gwd_pkg;

    // Week bits taken from the input field
    localparam int WEEK_BITS   = 13;
    localparam int WEEK_IN_W   = 13;
    // Day count: week * 7 + up to 49 days + 6 fits in three more bits
    localparam int DAY_W       = WEEK_BITS + 3;
    localparam int ALU_W       = 32;
    localparam int QUO_W       = 6;

    localparam logic [ALU_W-1:0] MS_PER_DAY        = 32'd86400000;
    localparam logic [DAY_W-1:0] EPOCH_DAY_OF_YEAR = DAY_W'(6);
    localparam logic [11:0]      EPOCH_YEAR        = 12'd1980;
    // 1980 modulo 4, 100 and 400
    localparam logic [1:0]       EPOCH_MOD4        = 2'd0;
    localparam logic [6:0]       EPOCH_MOD100      = 7'd80;
    localparam logic [8:0]       EPOCH_MOD400      = 9'd380;

    localparam logic [8:0]       DAYS_YEAR         = 9'd365;
    localparam logic [8:0]       DAYS_LEAP_YEAR    = 9'd366;
    localparam logic [3:0]       MONTH_JAN         = 4'd1;
    localparam logic [3:0]       MONTH_FEB         = 4'd2;
    localparam logic [3:0]       MONTH_DEC         = 4'd12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } t_state;

    // Year tracker control
    typedef struct packed {
        logic clear;
        logic step;
    } t_year_ctl;

    // Shared subtractor flags
    typedef struct packed {
        logic ge;
        logic gt;
    } t_cmp;

    // Length of a month, 1 is January
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        begin
            case (month) inside
                MONTH_FEB:                   len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
                default:                     len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

/* design/gps_week_offset_to_calendar_date_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_week_offset_to_calendar_date_core: GPS week + ms offset to calendar date
// Sequencer around one shared subtractor; turns week and offset into date.
// ----------------------------------------------------------------------------
// One item is handled at a time, all work running through a single 32-bit
// subtract/compare unit. The offset is divided by the day length by repeated
// subtraction (one whole day per step, up to 49 days), then whole years are
// stepped off from 1980 one at a time, then whole months up to December, and
// the date is handed to the output register.
// s_axis_tready is high only while the block is idle; the result sits in an
// output register, so a new item may be taken while it waits to be read.
// ----------------------------------------------------------------------------
module gps_week_offset_to_calendar_date_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // [12:0] gps_week, [44:13] offset_ms, [47:45] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // [4:0] day_of_month, [8:5] month,
                                       // [20:9] year, [47:21] ms_of_day
);
    import gwd_pkg::*;

    t_state             r_state, n_state;
    logic [ALU_W-1:0]   r_rem, n_rem;
    logic [QUO_W-1:0]   r_quo, n_quo;
    logic [WEEK_BITS-1:0] r_week, n_week;
    logic [DAY_W-1:0]   r_day, n_day;
    logic [3:0]         r_month, n_month;

    logic               r_out_valid, n_out_valid;
    logic [47:0]        r_out_data, n_out_data;

    logic [ALU_W-1:0]   w_alu_a, w_alu_b, w_diff;
    t_cmp               w_cmp;
    t_year_ctl          w_year_ctl;
    logic [11:0]        w_year;
    logic               w_leap;
    logic               w_in_acc, w_out_free;
    logic [WEEK_IN_W-1:0] w_in_week;

    assign w_in_week  = s_axis_tdata[WEEK_IN_W-1:0];
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    // Shared unit operand select
    always_comb begin
        w_alu_a = ALU_W'(r_day);
        w_alu_b = '0;
        case (r_state)
            ST_DIV: begin
                w_alu_a = r_rem;
                w_alu_b = MS_PER_DAY;
            end
            ST_YEAR:  w_alu_b = ALU_W'(w_leap ? DAYS_LEAP_YEAR : DAYS_YEAR);
            ST_MONTH: w_alu_b = ALU_W'(month_days(r_month, w_leap));
            default:  w_alu_b = '0;
        endcase
    end

    gwd_alu u_alu (
        .i_a    (w_alu_a),
        .i_b    (w_alu_b),
        .o_diff (w_diff),
        .o_cmp  (w_cmp)
    );

    gwd_year u_year (
        .i_clk  (i_clk),
        .i_ctl  (w_year_ctl),
        .o_year (w_year),
        .o_leap (w_leap)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_DIV;
            ST_DIV:   if (!w_cmp.ge) n_state = ST_YEAR;
            ST_YEAR:  if (!w_cmp.gt) n_state = ST_MONTH;
            ST_MONTH: if (!(r_month < MONTH_DEC && w_cmp.gt)) n_state = ST_DONE;
            ST_DONE:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        s_axis_tready    = (r_state == ST_IDLE);
        n_rem            = r_rem;
        n_quo            = r_quo;
        n_week           = r_week;
        n_day            = r_day;
        n_month          = r_month;
        n_out_valid      = r_out_valid && !m_axis_tready;
        n_out_data       = r_out_data;
        w_year_ctl.clear = 1'b0;
        w_year_ctl.step  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_rem            = s_axis_tdata[44:13];
                    n_quo            = '0;
                    n_week           = w_in_week[WEEK_BITS-1:0];
                    w_year_ctl.clear = 1'b1;
                end
            end
            ST_DIV: begin
                // Whole days out of the offset
                if (w_cmp.ge) begin
                    n_rem = w_diff;
                    n_quo = r_quo + QUO_W'(1);
                end else begin
                    // week * 7 + days + 6 gives the day number counted from 1 January 1980 (1 is 1 January)
                    n_day = {r_week, 3'b000} - DAY_W'(r_week) + DAY_W'(r_quo)
                            + EPOCH_DAY_OF_YEAR;
                end
            end
            ST_YEAR: begin
                if (w_cmp.gt) begin
                    n_day           = w_diff[DAY_W-1:0];
                    w_year_ctl.step = 1'b1;
                end else begin
                    n_month = MONTH_JAN;
                end
            end
            ST_MONTH: begin
                if (r_month < MONTH_DEC && w_cmp.gt) begin
                    n_day   = w_diff[DAY_W-1:0];
                    n_month = r_month + 4'd1;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_rem[26:0], w_year, r_month, r_day[4:0]};
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_week     <= n_week;
        r_day      <= n_day;
        r_month    <= n_month;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* design/gwd_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwd_alu: shared subtract and compare unit
// One 32-bit subtractor; gives a - b and the a >= b / a > b flags.
// ----------------------------------------------------------------------------
module gwd_alu (
    input  logic [gwd_pkg::ALU_W-1:0] i_a,
    input  logic [gwd_pkg::ALU_W-1:0] i_b,
    output logic [gwd_pkg::ALU_W-1:0] o_diff,
    output gwd_pkg::t_cmp             o_cmp
);
    import gwd_pkg::*;

    logic [ALU_W:0] w_full;

    // Borrow out of the top bit means a < b
    assign w_full     = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff     = w_full[ALU_W-1:0];
    assign o_cmp.ge   = ~w_full[ALU_W];
    assign o_cmp.gt   = ~w_full[ALU_W] && (w_full[ALU_W-1:0] != '0);

endmodule

/* design/gwd_year.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwd_year: year counter with Gregorian leap flag
// Tracks the year and its residues mod 4, 100 and 400 so no divider is needed.
// ----------------------------------------------------------------------------
module gwd_year (
    input  logic               i_clk,
    input  gwd_pkg::t_year_ctl i_ctl,
    output logic [11:0]        o_year,
    output logic               o_leap
);
    import gwd_pkg::*;

    logic [11:0] r_year;
    logic [1:0]  r_mod4;
    logic [6:0]  r_mod100;
    logic [8:0]  r_mod400;

    // Load epoch year or step one year forward
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_year   <= EPOCH_YEAR;
            r_mod4   <= EPOCH_MOD4;
            r_mod100 <= EPOCH_MOD100;
            r_mod400 <= EPOCH_MOD400;
        end else if (i_ctl.step) begin
            r_year   <= r_year + 12'd1;
            r_mod4   <= r_mod4 + 2'd1;
            r_mod100 <= (r_mod100 == 7'd99)  ? 7'd0 : r_mod100 + 7'd1;
            r_mod400 <= (r_mod400 == 9'd399) ? 9'd0 : r_mod400 + 9'd1;
        end
    end

    assign o_year = r_year;
    assign o_leap = (r_mod4 == 2'd0) && ((r_mod100 != 7'd0) || (r_mod400 == 9'd0));

endmodule
